@@ sv/phe_hist_pkg.sv @@
// ----------------------------------------------------------------------------
// phe_hist_pkg
// Shared constants and types of the photon event image histogram.
// ----------------------------------------------------------------------------
package phe_hist_pkg;

	localparam int X_SIZE = 140;
	localparam int Y_SIZE = 145;
	localparam int PIXELS = X_SIZE * Y_SIZE;
	localparam int ADDR_W = $clog2(PIXELS);
	localparam int COORD_W = 10;
	localparam int WORD_W = 64;
	localparam int CNT_W = 16;
	localparam int PKT_W = 32;
	localparam logic [7:0] HDR_MARK = 8'hFF;

	typedef enum logic [1:0] {
		CMD_STREAM = 2'd0,
		CMD_READ   = 2'd1,
		CMD_SECOND = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_HEADER  = 3'd0,
		ST_COUNTED = 3'd1,
		ST_DROPPED = 3'd2,
		ST_READ    = 3'd3,
		ST_SECOND  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INCR,
		OP_CLEAR
	} pix_op_t;

endpackage

@@ sv/phe_hist_ram.sv @@
// ----------------------------------------------------------------------------
// phe_hist_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module phe_hist_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/photon_event_image_histogram.sv @@
// ----------------------------------------------------------------------------
// photon_event_image_histogram
// Per-pixel 16-bit hit counts of a photon event stream, with packet counting,
// read-and-clear of single pixels and an end-of-second packet report.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------
//  in      | in_valid, in_stall | cmd, word, read_x, read_y
//  out     | out_valid,out_stall| status, pixel_value, packets_seen
//
// One word per cycle sustained while in_stall is low; an accepted input is
// decoded and its RAM read issued into the s1 register, then modified, written
// back to the RAM and registered into the output register.
// The pixel RAM has one read and one write port; a back-to-back hit on the
// same pixel is served from the last-write bypass register.
// After reset a clearing pass zeroes all 20300 pixel RAM entries, one entry per
// cycle; in_stall stays high until it is done.
// A stalled output holds the s1 word, which in turn raises in_stall.
// ----------------------------------------------------------------------------
module photon_event_image_histogram (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         cmd,
	input  logic [phe_hist_pkg::WORD_W-1:0]    word,
	input  logic [phe_hist_pkg::COORD_W-1:0]   read_x,
	input  logic [phe_hist_pkg::COORD_W-1:0]   read_y,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         status,
	output logic [phe_hist_pkg::CNT_W-1:0]     pixel_value,
	output logic [phe_hist_pkg::PKT_W-1:0]     packets_seen
);
	import phe_hist_pkg::*;

	localparam int PROD_W = 2 * COORD_W + 1;

	// clearing pass
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// stream state
	logic             first_pending_q;
	logic [PKT_W-1:0] pkt_cnt_q;

	// decode
	logic               accept;
	logic [COORD_W-1:0] px, py;
	logic               is_hdr, in_img;
	logic [PROD_W-1:0]  addr_wide;
	logic [ADDR_W-1:0]  addr_d;
	status_t            status_d;
	pix_op_t            op_d;
	logic [PKT_W-1:0]   pkts_d;

	// stage 1
	logic              valid_s1;
	status_t           status_s1;
	pix_op_t           op_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [PKT_W-1:0]  pkts_s1;
	logic              s1_go;

	// RAM and bypass
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CNT_W-1:0]  ram_wdata, ram_rdata;
	logic              wr_val_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [CNT_W-1:0]  wr_data_q;
	logic [CNT_W-1:0]  cur_val, new_val;

	// output register
	logic             out_valid_q;
	status_t          status_q;
	logic [CNT_W-1:0] pix_q;
	logic [PKT_W-1:0] pkts_q;

	assign s1_go    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = clearing_q || (valid_s1 && !s1_go);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		is_hdr = first_pending_q || (word[WORD_W-1 -: 8] == HDR_MARK);
		if (cmd == CMD_READ) begin
			px = read_x;
			py = read_y;
		end else begin
			px = word[WORD_W-1 -: COORD_W];
			py = word[WORD_W-COORD_W-1 -: COORD_W];
		end
		in_img    = (PROD_W'(px) < PROD_W'(X_SIZE)) && (PROD_W'(py) < PROD_W'(Y_SIZE));
		addr_wide = PROD_W'(px) * PROD_W'(Y_SIZE) + PROD_W'(py);
		addr_d    = addr_wide[ADDR_W-1:0];

		status_d = ST_DROPPED;
		op_d     = OP_NONE;
		pkts_d   = '0;
		unique case (cmd)
			CMD_STREAM: begin
				if (is_hdr) begin
					status_d = ST_HEADER;
				end else if (in_img) begin
					status_d = ST_COUNTED;
					op_d     = OP_INCR;
				end
			end
			CMD_READ: begin
				status_d = ST_READ;
				if (in_img) begin
					op_d = OP_CLEAR;
				end
			end
			CMD_SECOND: begin
				status_d = ST_SECOND;
				pkts_d   = pkt_cnt_q;
			end
			default: begin
				status_d = ST_DROPPED;
			end
		endcase
	end

	// packet counting and first-word flag, settled at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pending_q <= 1'b1;
			pkt_cnt_q       <= '0;
		end else if (accept) begin
			if (cmd == CMD_STREAM && is_hdr) begin
				first_pending_q <= 1'b0;
				if (pkt_cnt_q != '1) begin
					pkt_cnt_q <= pkt_cnt_q + 1'b1;
				end
			end else if (cmd == CMD_SECOND) begin
				pkt_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == ADDR_W'(PIXELS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			op_s1     <= op_d;
			addr_s1   <= addr_d;
			pkts_s1   <= pkts_d;
		end
	end

	// bypass: RAM read issued on the edge of the previous write sees stale data
	assign cur_val = (wr_val_q && wr_addr_q == addr_s1) ? wr_data_q : ram_rdata;
	assign new_val = (op_s1 == OP_INCR) ? cur_val + 1'b1 : '0;

	assign ram_re    = accept && op_d != OP_NONE;
	assign ram_we    = clearing_q || (s1_go && op_s1 != OP_NONE);
	assign ram_waddr = clearing_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clearing_q ? '0 : new_val;

	phe_hist_ram #(
		.WIDTH(CNT_W),
		.DEPTH(PIXELS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_d),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_val_q <= 1'b0;
		end else if (s1_go && op_s1 != OP_NONE) begin
			wr_val_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && op_s1 != OP_NONE) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= new_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			status_q <= status_s1;
			pix_q    <= (op_s1 == OP_CLEAR) ? cur_val : '0;
			pkts_q   <= pkts_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign pixel_value  = pix_q;
	assign packets_seen = pkts_q;

endmodule
